[design/button_event_qualifier_unit_defines.svh]
// assertion macros for the button event qualifier
// used by the top level only; expects aclk and aresetn in scope
`ifndef BUTTON_EVENT_QUALIFIER_UNIT_DEFINES_SVH
`define BUTTON_EVENT_QUALIFIER_UNIT_DEFINES_SVH

// same-cycle implication
`define BEQ_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("button event qualifier: same-cycle check failed");

// next-cycle implication
`define BEQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("button event qualifier: next-cycle check failed");

`endif

[design/beq_pkg.sv]
// shared types and constants for the button event qualifier
// no dependencies
package beq_pkg;

    localparam int TIME_BITS_DEF = 32;
    localparam int CFG_BITS      = 16;
    localparam int CFG_IDX_BITS  = 2;
    localparam int EV_BITS       = 3;
    localparam int NOW_BITS      = 32;
    localparam int BTN_BITS      = 3;
    localparam int S_DATA_BITS   = 40;
    localparam int M_DATA_BITS   = 8;

    localparam logic [CFG_BITS-1:0] RST_REPEAT_DELAY    = 16'd1000;
    localparam logic [CFG_BITS-1:0] RST_REPEAT_INTERVAL = 16'd80;
    localparam logic [CFG_BITS-1:0] RST_LOCKOUT         = 16'd150;
    localparam logic [CFG_BITS-1:0] RST_DOUBLE_CLICK    = 16'd250;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_REPEAT_DELAY    = 2'd0,
        CFG_REPEAT_INTERVAL = 2'd1,
        CFG_LOCKOUT         = 2'd2,
        CFG_DOUBLE_CLICK    = 2'd3
    } cfg_idx_t;

    typedef enum logic [EV_BITS-1:0] {
        EV_NONE   = 3'd0,
        EV_UP     = 3'd1,
        EV_DOWN   = 3'd2,
        EV_SELECT = 3'd3,
        EV_BACK   = 3'd4
    } event_t;

    typedef struct packed {
        logic [CFG_BITS-1:0] repeat_delay;
        logic [CFG_BITS-1:0] repeat_interval;
        logic [CFG_BITS-1:0] lockout;
        logic [CFG_BITS-1:0] double_click;
    } cfg_t;

    // up/down lane finding
    typedef struct packed {
        logic fire;
    } dir_stat_t;

    // select lane findings
    typedef struct packed {
        logic expire;
        logic back;
    } sel_stat_t;

    // scan enables from the merge stage
    typedef struct packed {
        logic up;
        logic dn;
        logic sel;
    } lane_en_t;

endpackage

[design/beq_dir_lane.sv]
// up or down button lane: lockout, press detect and auto-repeat
// depends on beq_pkg
module beq_dir_lane #(
    parameter int TIME_BITS = beq_pkg::TIME_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  beq_pkg::cfg_t         cfg,
    input  logic [TIME_BITS-1:0]  now,
    input  logic                  pressed,
    input  logic                  take,
    output beq_pkg::dir_stat_t    stat
);

    logic                 held_reg, held_next;
    logic [TIME_BITS-1:0] nat_reg, nat_next;
    logic [TIME_BITS-1:0] press_reg, press_next;
    logic [TIME_BITS-1:0] lrt_reg, lrt_next;

    logic                 press_ok;
    logic                 rep;
    logic [TIME_BITS-1:0] el_press;
    logic [TIME_BITS-1:0] el_rep;

    assign el_press = now - press_reg;
    assign el_rep   = now - lrt_reg;
    assign press_ok = pressed && !held_reg && !(now < nat_reg);
    assign rep      = pressed && held_reg
                      && (el_press >= TIME_BITS'(cfg.repeat_delay))
                      && (el_rep >= TIME_BITS'(cfg.repeat_interval));

    assign stat.fire = press_ok || rep;

    always_comb begin
        held_next  = held_reg;
        nat_next   = nat_reg;
        press_next = press_reg;
        lrt_next   = lrt_reg;
        if (take) begin
            if (press_ok) begin
                held_next  = 1'b1;
                nat_next   = now + TIME_BITS'(cfg.lockout);
                press_next = now;
                lrt_next   = now;
            end else if (rep) begin
                lrt_next = now;
            end else if (!pressed && held_reg) begin
                held_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg  <= 1'b0;
            nat_reg   <= '0;
            press_reg <= '0;
            lrt_reg   <= '0;
        end else begin
            held_reg  <= held_next;
            nat_reg   <= nat_next;
            press_reg <= press_next;
            lrt_reg   <= lrt_next;
        end
    end

endmodule

[design/beq_sel_lane.sv]
// select button lane: lockout, pending single click and double-click
// depends on beq_pkg
module beq_sel_lane #(
    parameter int TIME_BITS = beq_pkg::TIME_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  beq_pkg::cfg_t         cfg,
    input  logic [TIME_BITS-1:0]  now,
    input  logic                  pressed,
    input  logic                  accept,
    input  logic                  take,
    output beq_pkg::sel_stat_t    stat
);

    logic                 held_reg, held_next;
    logic                 pend_reg, pend_next;
    logic [TIME_BITS-1:0] nat_reg, nat_next;
    logic [TIME_BITS-1:0] spt_reg, spt_next;

    logic                 press_ok;
    logic [TIME_BITS-1:0] el_sel;

    assign el_sel   = now - spt_reg;
    assign press_ok = pressed && !held_reg && !(now < nat_reg);

    assign stat.expire = pend_reg && (el_sel >= TIME_BITS'(cfg.double_click));
    // expired pending is handled first, so a live pending is inside the window
    assign stat.back   = press_ok && pend_reg;

    always_comb begin
        held_next = held_reg;
        pend_next = pend_reg;
        nat_next  = nat_reg;
        spt_next  = spt_reg;
        if (accept && stat.expire) begin
            pend_next = 1'b0;
        end else if (take) begin
            if (press_ok) begin
                held_next = 1'b1;
                nat_next  = now + TIME_BITS'(cfg.lockout);
                if (pend_reg) begin
                    pend_next = 1'b0;
                end else begin
                    pend_next = 1'b1;
                    spt_next  = now;
                end
            end else if (!pressed && held_reg) begin
                held_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= 1'b0;
            pend_reg <= 1'b0;
            nat_reg  <= '0;
            spt_reg  <= '0;
        end else begin
            held_reg <= held_next;
            pend_reg <= pend_next;
            nat_reg  <= nat_next;
            spt_reg  <= spt_next;
        end
    end

endmodule

[design/beq_merge.sv]
// merge stage: scan priority across lanes and the output register
// depends on beq_pkg
module beq_merge (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  beq_pkg::dir_stat_t    up_stat,
    input  beq_pkg::dir_stat_t    dn_stat,
    input  beq_pkg::sel_stat_t    sel_stat,
    input  logic                  accept,
    input  logic                  out_take,
    output beq_pkg::lane_en_t     lane_en,
    output logic                  out_valid,
    output beq_pkg::event_t       out_code
);

    beq_pkg::event_t code;
    logic            valid_reg, valid_next;
    beq_pkg::event_t code_reg, code_next;

    // first event found stops later lanes
    assign lane_en.up  = !sel_stat.expire;
    assign lane_en.dn  = lane_en.up && !up_stat.fire;
    assign lane_en.sel = lane_en.dn && !dn_stat.fire;

    always_comb begin
        if (sel_stat.expire) begin
            code = beq_pkg::EV_SELECT;
        end else if (up_stat.fire) begin
            code = beq_pkg::EV_UP;
        end else if (dn_stat.fire) begin
            code = beq_pkg::EV_DOWN;
        end else if (sel_stat.back) begin
            code = beq_pkg::EV_BACK;
        end else begin
            code = beq_pkg::EV_NONE;
        end
    end

    always_comb begin
        valid_next = valid_reg;
        code_next  = code_reg;
        if (accept) begin
            valid_next = 1'b1;
            code_next  = code;
        end else if (out_take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        code_reg <= code_next;
    end

    assign out_valid = valid_reg;
    assign out_code  = code_reg;

endmodule

[design/button_event_qualifier_unit.sv]
// button event qualifier top level: config registers, three button lanes, merge stage
// depends on beq_pkg, beq_dir_lane, beq_sel_lane, beq_merge and the assertion macros
//
// One poll (timestamp plus up/down/select levels) is taken per clock while
// s_tready is high and gives exactly one event code, held in the output register
// in the cycle after the transaction. The three button lanes evaluate in parallel
// and the merge stage applies the expired select, up, down, back priority, so
// sustained rate is one poll per cycle; s_tready is high whenever the output
// register is empty or being drained in the same cycle. Config writes take effect
// at the next edge and should only be made while no poll is in flight.
`include "button_event_qualifier_unit_defines.svh"

module button_event_qualifier_unit #(
    parameter int TIME_BITS = beq_pkg::TIME_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [31:0] now_ms, [34:32] buttons_pressed, [39:35] zero
    input  logic [beq_pkg::S_DATA_BITS-1:0]      s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [2:0] event_code, [7:3] zero
    output logic [beq_pkg::M_DATA_BITS-1:0]      m_tdata,
    input  logic                                 cfg_we,
    input  logic [beq_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [beq_pkg::CFG_BITS-1:0]         cfg_wdata
);

    beq_pkg::cfg_t      cfg_reg, cfg_next;
    logic [TIME_BITS-1:0] now;
    logic [beq_pkg::BTN_BITS-1:0] btn;
    logic               s_accept;
    logic               out_take;
    beq_pkg::dir_stat_t up_stat;
    beq_pkg::dir_stat_t dn_stat;
    beq_pkg::sel_stat_t sel_stat;
    beq_pkg::lane_en_t  lane_en;
    beq_pkg::event_t    out_code;

    generate
        if (TIME_BITS <= beq_pkg::NOW_BITS) begin : g_now_narrow
            assign now = s_tdata[TIME_BITS-1:0];
        end else begin : g_now_wide
            assign now = TIME_BITS'(s_tdata[beq_pkg::NOW_BITS-1:0]);
        end
    endgenerate

    assign btn = s_tdata[beq_pkg::NOW_BITS +: beq_pkg::BTN_BITS];

    // config registers
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (beq_pkg::cfg_idx_t'(cfg_index))
                beq_pkg::CFG_REPEAT_DELAY:    cfg_next.repeat_delay    = cfg_wdata;
                beq_pkg::CFG_REPEAT_INTERVAL: cfg_next.repeat_interval = cfg_wdata;
                beq_pkg::CFG_LOCKOUT:         cfg_next.lockout         = cfg_wdata;
                beq_pkg::CFG_DOUBLE_CLICK:    cfg_next.double_click    = cfg_wdata;
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.repeat_delay    <= beq_pkg::RST_REPEAT_DELAY;
            cfg_reg.repeat_interval <= beq_pkg::RST_REPEAT_INTERVAL;
            cfg_reg.lockout         <= beq_pkg::RST_LOCKOUT;
            cfg_reg.double_click    <= beq_pkg::RST_DOUBLE_CLICK;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign s_tready = !m_tvalid || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign out_take = m_tvalid && m_tready;

    beq_dir_lane #(.TIME_BITS(TIME_BITS)) u_lane_up (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .now     (now),
        .pressed (btn[0]),
        .take    (s_accept && lane_en.up),
        .stat    (up_stat)
    );

    beq_dir_lane #(.TIME_BITS(TIME_BITS)) u_lane_dn (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .now     (now),
        .pressed (btn[1]),
        .take    (s_accept && lane_en.dn),
        .stat    (dn_stat)
    );

    beq_sel_lane #(.TIME_BITS(TIME_BITS)) u_lane_sel (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .now     (now),
        .pressed (btn[2]),
        .accept  (s_accept),
        .take    (s_accept && lane_en.sel),
        .stat    (sel_stat)
    );

    beq_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .up_stat   (up_stat),
        .dn_stat   (dn_stat),
        .sel_stat  (sel_stat),
        .accept    (s_accept),
        .out_take  (out_take),
        .lane_en   (lane_en),
        .out_valid (m_tvalid),
        .out_code  (out_code)
    );

    assign m_tdata = beq_pkg::M_DATA_BITS'(out_code);

    // a full, stalled output register must block new transactions
    `BEQ_ASSERT_SAME(a_no_overwrite, m_tvalid && !m_tready, !s_tready)
    // an expired pending select wins over every lane
    `BEQ_ASSERT_NEXT(a_expire_select, s_accept && sel_stat.expire,
                     m_tdata[2:0] == beq_pkg::EV_SELECT)
    // an up event blocks the down and select lanes
    `BEQ_ASSERT_SAME(a_up_blocks, up_stat.fire && lane_en.up, !lane_en.dn && !lane_en.sel)
    // a transaction always leaves a result behind
    `BEQ_ASSERT_NEXT(a_result_follows, s_accept, m_tvalid)

endmodule

[dv/testbench.sv]
// self-checking testbench for button_event_qualifier_unit: directed and random polls,
// an internal event predictor and a scoreboard on the result stream
// depends on beq_pkg and the design sources
`timescale 1ns / 100ps

module testbench;

    localparam int CYCLE_LIMIT = 300000;

    logic                              aclk = 1'b0;
    logic                              aresetn = 1'b0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    // [31:0] now_ms, [34:32] buttons_pressed, [39:35] zero
    logic [beq_pkg::S_DATA_BITS-1:0]   s_tdata = '0;
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    // [2:0] event_code, [7:3] zero
    logic [beq_pkg::M_DATA_BITS-1:0]   m_tdata;
    logic                              cfg_we = 1'b0;
    logic [beq_pkg::CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [beq_pkg::CFG_BITS-1:0]      cfg_wdata = '0;

    int               cycle_count = 0;
    int               err_count = 0;
    int               src_idle_pct = 0;
    int               sink_stall_pct = 0;
    beq_pkg::event_t  expected_codes[$];
    beq_pkg::event_t  want_code;

    // predictor state
    logic [beq_pkg::CFG_BITS-1:0] cfg_delay, cfg_interval, cfg_lockout, cfg_dclick;
    logic                held_q [3];
    logic [31:0]         press_at [2];
    logic [31:0]         repeat_at [2];
    logic [31:0]         unlock_at [3];
    logic                sel_armed;
    logic [31:0]         sel_at;

    button_event_qualifier_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("cycle %0d: %s (got %0d, expected %0d)", cycle_count, what, got, want);
        err_count++;
    endtask

    // scoreboard on the result stream
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_codes.size() == 0) begin
                report_mismatch("event with none pending",
                                int'(m_tdata[beq_pkg::EV_BITS-1:0]), 0);
            end else begin
                want_code = expected_codes.pop_front();
                if (m_tdata[beq_pkg::EV_BITS-1:0] !== want_code)
                    report_mismatch("event_code mismatch",
                                    int'(m_tdata[beq_pkg::EV_BITS-1:0]), int'(want_code));
            end
        end
    end

    function automatic void reset_predictor();
        cfg_delay    = beq_pkg::RST_REPEAT_DELAY;
        cfg_interval = beq_pkg::RST_REPEAT_INTERVAL;
        cfg_lockout  = beq_pkg::RST_LOCKOUT;
        cfg_dclick   = beq_pkg::RST_DOUBLE_CLICK;
        for (int b = 0; b < 3; b++) begin
            held_q[b]    = 1'b0;
            unlock_at[b] = '0;
        end
        for (int b = 0; b < 2; b++) begin
            press_at[b]  = '0;
            repeat_at[b] = '0;
        end
        sel_armed = 1'b0;
        sel_at    = '0;
    endfunction

    function automatic beq_pkg::event_t qualify_poll(input logic [31:0] now,
                                                     input logic [2:0] lvl);
        beq_pkg::event_t ev;
        logic            hit;
        ev  = beq_pkg::EV_NONE;
        hit = 1'b0;
        if (sel_armed && (now - sel_at) >= {16'b0, cfg_dclick}) begin
            sel_armed = 1'b0;
            ev  = beq_pkg::EV_SELECT;
            hit = 1'b1;
        end
        for (int b = 0; b < 3; b++) begin
            if (!hit && !(lvl[b] && !held_q[b] && now < unlock_at[b])) begin
                if (lvl[b] && !held_q[b]) begin
                    held_q[b]    = 1'b1;
                    unlock_at[b] = now + {16'b0, cfg_lockout};
                    if (b < 2) begin
                        press_at[b]  = now;
                        repeat_at[b] = now;
                        ev  = (b == 0) ? beq_pkg::EV_UP : beq_pkg::EV_DOWN;
                        hit = 1'b1;
                    end else if (sel_armed && (now - sel_at) < {16'b0, cfg_dclick}) begin
                        sel_armed = 1'b0;
                        ev  = beq_pkg::EV_BACK;
                        hit = 1'b1;
                    end else begin
                        sel_armed = 1'b1;
                        sel_at    = now;
                    end
                end
                if (!hit && lvl[b] && held_q[b] && b < 2) begin
                    if ((now - press_at[b]) >= {16'b0, cfg_delay} &&
                        (now - repeat_at[b]) >= {16'b0, cfg_interval}) begin
                        repeat_at[b] = now;
                        ev  = (b == 0) ? beq_pkg::EV_UP : beq_pkg::EV_DOWN;
                        hit = 1'b1;
                    end
                end
                if (!hit && !lvl[b] && held_q[b])
                    held_q[b] = 1'b0;
            end
        end
        return ev;
    endfunction

    task automatic send_poll(input logic [31:0] stamp, input logic [2:0] lvl);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, lvl, stamp};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_codes.push_back(qualify_poll(stamp, lvl));
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_codes.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic load_config(input logic [15:0] d, input logic [15:0] i,
                               input logic [15:0] l, input logic [15:0] c);
        logic [15:0]       vals [4];
        beq_pkg::cfg_idx_t idx;
        vals = '{d, i, l, c};
        drain_results();
        for (int k = 0; k < 4; k++) begin
            idx = beq_pkg::cfg_idx_t'(k);
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_wdata <= vals[k];
            @(posedge aclk);
            case (idx)
                beq_pkg::CFG_REPEAT_DELAY:    cfg_delay    = vals[k];
                beq_pkg::CFG_REPEAT_INTERVAL: cfg_interval = vals[k];
                beq_pkg::CFG_LOCKOUT:         cfg_lockout  = vals[k];
                beq_pkg::CFG_DOUBLE_CLICK:    cfg_dclick   = vals[k];
                default: ;
            endcase
        end
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic test_press_and_repeat();
        send_poll(32'd0, 3'b000);
        send_poll(32'd0, 3'b001);
        send_poll(32'd100, 3'b001);
        send_poll(32'd1000, 3'b001);
        send_poll(32'd1080, 3'b001);
        send_poll(32'd1100, 3'b000);
    endtask

    task automatic test_lockout_and_wrap();
        send_poll(32'd1200, 3'b001);
        send_poll(32'd1250, 3'b000);
        // inside lockout, ignored
        send_poll(32'd1300, 3'b001);
        send_poll(32'd1400, 3'b010);
        // lockout end wraps past zero, cut short
        send_poll(32'hFFFF_FF80, 3'b001);
        send_poll(32'hFFFF_FF90, 3'b000);
        send_poll(32'hFFFF_FFA0, 3'b001);
    endtask

    task automatic test_select_back();
        send_poll(32'h0000_0100, 3'b100);
        send_poll(32'h0000_0150, 3'b000);
        send_poll(32'h0000_01C0, 3'b100);
        send_poll(32'h0000_0300, 3'b000);
        send_poll(32'h0000_0400, 3'b100);
        send_poll(32'h0000_0410, 3'b000);
        send_poll(32'h0000_0600, 3'b000);
        send_poll(32'h0000_0800, 3'b111);
    endtask

    task automatic test_zero_registers();
        load_config(16'd0, 16'd0, 16'd0, 16'd0);
        send_poll(32'h0000_0900, 3'b001);
        send_poll(32'h0000_0900, 3'b001);
        send_poll(32'h0000_0901, 3'b100);
        send_poll(32'h0000_0901, 3'b000);
    endtask

    task automatic run_random_phase(input logic [15:0] d, input logic [15:0] i,
                                    input logic [15:0] l, input logic [15:0] c,
                                    input int phase, input int n);
        logic [15:0] regs [4];
        logic [31:0] stamp;
        logic [2:0]  lvl;
        int          sent;
        int          hold;
        int          span;
        regs = '{d, i, l, c};
        load_config(d, i, l, c);
        case (phase)
            0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin src_idle_pct = 61; sink_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  sink_stall_pct = 61; end
            default: begin src_idle_pct = 21; sink_stall_pct = 21; end
        endcase
        if ($urandom_range(0, 2) == 0)
            stamp = 32'hFFFF_0000 + $urandom_range(0, 65535);
        else
            stamp = $urandom;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(0, 99) < 12) begin
                stamp = $urandom;
                send_poll(stamp, 3'($urandom_range(0, 7)));
                sent++;
            end else begin
                case ($urandom_range(0, 3))
                    0:       lvl = 3'b000;
                    1:       lvl = 3'b001 << $urandom_range(0, 2);
                    default: lvl = 3'($urandom_range(0, 7));
                endcase
                hold = $urandom_range(1, 10);
                for (int k = 0; k < hold && sent < n; k++) begin
                    span  = int'(regs[$urandom_range(0, 3)]) / 2 + 2;
                    stamp = stamp + $urandom_range(0, span);
                    send_poll(stamp, lvl);
                    sent++;
                end
            end
        end
    endtask

    task automatic test_random_traffic();
        run_random_phase(beq_pkg::RST_REPEAT_DELAY, beq_pkg::RST_REPEAT_INTERVAL,
                         beq_pkg::RST_LOCKOUT, beq_pkg::RST_DOUBLE_CLICK, 0, 242);
        run_random_phase(16'd0, 16'd0, 16'd0, 16'd0, 1, 242);
        run_random_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2, 242);
        run_random_phase(16'($urandom_range(0, 40)), 16'($urandom_range(0, 40)),
                         16'($urandom_range(0, 40)), 16'($urandom_range(0, 40)), 3, 242);
        run_random_phase(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                         0, 242);
        run_random_phase(16'($urandom_range(0, 300)), 16'($urandom_range(0, 60)),
                         16'($urandom_range(0, 200)), 16'($urandom_range(0, 300)), 3, 242);
    endtask

    initial begin
        reset_predictor();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_press_and_repeat();
        test_lockout_and_wrap();
        test_select_back();
        test_zero_registers();
        test_random_traffic();

        drain_results();
        repeat (4) @(posedge aclk);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[filelist.f]
+incdir+design
design/beq_pkg.sv
design/beq_dir_lane.sv
design/beq_sel_lane.sv
design/beq_merge.sv
design/button_event_qualifier_unit.sv
dv/testbench.sv
